// ===== rtl/core/spline_contour_lag_error_defines.svh =====
// Assertion macros for the spline contour and lag error block.
`ifndef SPLINE_CONTOUR_LAG_ERROR_DEFINES_SVH
`define SPLINE_CONTOUR_LAG_ERROR_DEFINES_SVH
`ifndef SYNTHESIS
`define SCL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("scl assertion failed");
`define SCL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("scl assertion failed");
`else
`define SCL_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define SCL_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/core/scl_pkg.sv =====
package scl_pkg;

    localparam int NUM_COEF   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int COEF_SEL_W = 3;

    localparam logic [CFG_IDX_W-1:0] NUM_COEF_IDX = 4'd8;

    localparam int COEF_X_CUBIC  = 0;
    localparam int COEF_X_SQUARE = 1;
    localparam int COEF_X_LINEAR = 2;
    localparam int COEF_X_CONST  = 3;
    localparam int COEF_Y_CUBIC  = 4;
    localparam int COEF_Y_SQUARE = 5;
    localparam int COEF_Y_LINEAR = 6;
    localparam int COEF_Y_CONST  = 7;

    // front-end pipeline depth
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = 2;

    typedef struct packed {
        logic load;
        logic valid_in;
    } scl_ctl_t;

endpackage

// ===== rtl/core/scl_if.sv =====
interface scl_pos_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] robot_x;
    logic signed [W-1:0] robot_y;
    logic signed [W-1:0] path_offset;
    modport source (output valid, robot_x, robot_y, path_offset, input ready);
    modport sink   (input valid, robot_x, robot_y, path_offset, output ready);
endinterface

interface scl_err_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] contour_err;
    logic signed [W-1:0] lag_error;
    logic                degenerate;
    modport source (output valid, contour_err, lag_error, degenerate, input ready);
    modport sink   (input valid, contour_err, lag_error, degenerate, output ready);
endinterface

interface scl_cfg_if #(parameter int W = 32);
    logic                           valid;
    logic                           ready;
    logic [scl_pkg::CFG_IDX_W-1:0]  index;
    logic [W-1:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/scl_qmul.sv =====
module scl_qmul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p
);

    logic             neg;
    logic [W-1:0]     ma;
    logic [W-1:0]     mb;
    logic [2*W-1:0]   pr;
    logic [2*W-F:0]   sh;
    logic [2*W-F:0]   lim;
    logic [2*W-F:0]   mag;
    logic [W-1:0]     m;

    // floor rounding, saturated
    always_comb
    begin
        neg = a[W-1] ^ b[W-1];
        ma  = a[W-1] ? W'(-a) : W'(a);
        mb  = b[W-1] ? W'(-b) : W'(b);
        pr  = (2*W)'(ma) * (2*W)'(mb);
        sh  = (2*W-F+1)'(pr[2*W-1:F]) + (2*W-F+1)'(neg && (pr[F-1:0] != '0));
        lim = (2*W-F+1)'({1'b0, {(W-1){1'b1}}}) + (2*W-F+1)'(neg);
        mag = (sh > lim) ? lim : sh;
        m   = mag[W-1:0];
        p   = neg ? W'(-$signed(m)) : $signed(m);
    end

endmodule

// ===== rtl/core/scl_front.sv =====
module scl_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [5:0]          load,
    input  logic                vin,
    output logic [5:0]          vld,
    input  logic signed [W-1:0] coef [scl_pkg::NUM_COEF],
    input  logic signed [W-1:0] rx_i,
    input  logic signed [W-1:0] ry_i,
    input  logic signed [W-1:0] t_i,
    output logic [2*W-1:0]      s_o,
    output logic signed [W-1:0] ex_o,
    output logic signed [W-1:0] ey_o,
    output logic [W-1:0]        mdx_o,
    output logic [W-1:0]        mdy_o,
    output logic                sdx_o,
    output logic                sdy_o
);

    localparam logic signed [W+2:0] SMAX = (W+3)'((64'd1 << (W-1)) - 64'd1);
    localparam logic signed [W+2:0] SMIN = -SMAX - (W+3)'(1);

    function automatic logic signed [W+2:0] ext(input logic signed [W-1:0] v);
        return (W+3)'(v);
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] v);
        logic signed [W+2:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return c[W-1:0];
    endfunction

    logic [5:0] vld_reg;

    logic signed [W-1:0] s0_t_reg, s0_rx_reg, s0_ry_reg, s0_t2_reg;
    logic signed [W-1:0] s0_pbtx_reg, s0_pbty_reg, s0_pctx_reg, s0_pcty_reg;
    logic signed [W-1:0] s0_t2_next, s0_pbtx_next, s0_pbty_next, s0_pctx_next, s0_pcty_next;

    logic signed [W-1:0] s1_rx_reg, s1_ry_reg, s1_t3_reg;
    logic signed [W-1:0] s1_pbt2x_reg, s1_pbt2y_reg, s1_pat2x_reg, s1_pat2y_reg;
    logic signed [W-1:0] s1_pbtx_reg, s1_pbty_reg, s1_pctx_reg, s1_pcty_reg;
    logic signed [W-1:0] s1_t3_next, s1_pbt2x_next, s1_pbt2y_next, s1_pat2x_next, s1_pat2y_next;

    logic signed [W-1:0] s2_rx_reg, s2_ry_reg, s2_pat3x_reg, s2_pat3y_reg;
    logic signed [W-1:0] s2_pbt2x_reg, s2_pbt2y_reg, s2_pat2x_reg, s2_pat2y_reg;
    logic signed [W-1:0] s2_pbtx_reg, s2_pbty_reg, s2_pctx_reg, s2_pcty_reg;
    logic signed [W-1:0] s2_pat3x_next, s2_pat3y_next;

    logic signed [W-1:0] s3_rx_reg, s3_ry_reg, s3_px_reg, s3_py_reg, s3_dx_reg, s3_dy_reg;
    logic signed [W-1:0] s3_px_next, s3_py_next, s3_dx_next, s3_dy_next;

    logic signed [W-1:0] s4_ex_reg, s4_ey_reg;
    logic [W-1:0]        s4_mdx_reg, s4_mdy_reg;
    logic [2*W-1:0]      s4_sqx_reg, s4_sqy_reg;
    logic                s4_sdx_reg, s4_sdy_reg;
    logic signed [W-1:0] s4_ex_next, s4_ey_next;
    logic [W-1:0]        s4_mdx_next, s4_mdy_next;

    logic [2*W-1:0]      s5_s_reg;
    logic signed [W-1:0] s5_ex_reg, s5_ey_reg;
    logic [W-1:0]        s5_mdx_reg, s5_mdy_reg;
    logic                s5_sdx_reg, s5_sdy_reg;

    scl_qmul #(.W(W), .F(F)) u_t2   (.a(t_i), .b(t_i), .p(s0_t2_next));
    scl_qmul #(.W(W), .F(F)) u_pbtx (.a(coef[scl_pkg::COEF_X_SQUARE]), .b(t_i), .p(s0_pbtx_next));
    scl_qmul #(.W(W), .F(F)) u_pbty (.a(coef[scl_pkg::COEF_Y_SQUARE]), .b(t_i), .p(s0_pbty_next));
    scl_qmul #(.W(W), .F(F)) u_pctx (.a(coef[scl_pkg::COEF_X_LINEAR]), .b(t_i), .p(s0_pctx_next));
    scl_qmul #(.W(W), .F(F)) u_pcty (.a(coef[scl_pkg::COEF_Y_LINEAR]), .b(t_i), .p(s0_pcty_next));

    scl_qmul #(.W(W), .F(F)) u_t3    (.a(s0_t2_reg), .b(s0_t_reg), .p(s1_t3_next));
    scl_qmul #(.W(W), .F(F)) u_pbt2x (.a(coef[scl_pkg::COEF_X_SQUARE]), .b(s0_t2_reg),
                                      .p(s1_pbt2x_next));
    scl_qmul #(.W(W), .F(F)) u_pbt2y (.a(coef[scl_pkg::COEF_Y_SQUARE]), .b(s0_t2_reg),
                                      .p(s1_pbt2y_next));
    scl_qmul #(.W(W), .F(F)) u_pat2x (.a(coef[scl_pkg::COEF_X_CUBIC]), .b(s0_t2_reg),
                                      .p(s1_pat2x_next));
    scl_qmul #(.W(W), .F(F)) u_pat2y (.a(coef[scl_pkg::COEF_Y_CUBIC]), .b(s0_t2_reg),
                                      .p(s1_pat2y_next));

    scl_qmul #(.W(W), .F(F)) u_pat3x (.a(coef[scl_pkg::COEF_X_CUBIC]), .b(s1_t3_reg),
                                      .p(s2_pat3x_next));
    scl_qmul #(.W(W), .F(F)) u_pat3y (.a(coef[scl_pkg::COEF_Y_CUBIC]), .b(s1_t3_reg),
                                      .p(s2_pat3y_next));

    always_comb
    begin
        s3_px_next = sat(ext(s2_pat3x_reg) + ext(s2_pbt2x_reg) + ext(s2_pctx_reg)
                         + ext(coef[scl_pkg::COEF_X_CONST]));
        s3_py_next = sat(ext(s2_pat3y_reg) + ext(s2_pbt2y_reg) + ext(s2_pcty_reg)
                         + ext(coef[scl_pkg::COEF_Y_CONST]));
        s3_dx_next = sat((ext(s2_pat2x_reg) <<< 1) + ext(s2_pat2x_reg)
                         + (ext(s2_pbtx_reg) <<< 1) + ext(coef[scl_pkg::COEF_X_LINEAR]));
        s3_dy_next = sat((ext(s2_pat2y_reg) <<< 1) + ext(s2_pat2y_reg)
                         + (ext(s2_pbty_reg) <<< 1) + ext(coef[scl_pkg::COEF_Y_LINEAR]));
        s4_ex_next  = sat(ext(s3_rx_reg) - ext(s3_px_reg));
        s4_ey_next  = sat(ext(s3_ry_reg) - ext(s3_py_reg));
        s4_mdx_next = s3_dx_reg[W-1] ? W'(-s3_dx_reg) : W'(s3_dx_reg);
        s4_mdy_next = s3_dy_reg[W-1] ? W'(-s3_dy_reg) : W'(s3_dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[0]) vld_reg[0] <= vin;
            if (load[1]) vld_reg[1] <= vld_reg[0];
            if (load[2]) vld_reg[2] <= vld_reg[1];
            if (load[3]) vld_reg[3] <= vld_reg[2];
            if (load[4]) vld_reg[4] <= vld_reg[3];
            if (load[5]) vld_reg[5] <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_t_reg    <= t_i;
            s0_rx_reg   <= rx_i;
            s0_ry_reg   <= ry_i;
            s0_t2_reg   <= s0_t2_next;
            s0_pbtx_reg <= s0_pbtx_next;
            s0_pbty_reg <= s0_pbty_next;
            s0_pctx_reg <= s0_pctx_next;
            s0_pcty_reg <= s0_pcty_next;
        end
        if (load[1])
        begin
            s1_rx_reg    <= s0_rx_reg;
            s1_ry_reg    <= s0_ry_reg;
            s1_t3_reg    <= s1_t3_next;
            s1_pbt2x_reg <= s1_pbt2x_next;
            s1_pbt2y_reg <= s1_pbt2y_next;
            s1_pat2x_reg <= s1_pat2x_next;
            s1_pat2y_reg <= s1_pat2y_next;
            s1_pbtx_reg  <= s0_pbtx_reg;
            s1_pbty_reg  <= s0_pbty_reg;
            s1_pctx_reg  <= s0_pctx_reg;
            s1_pcty_reg  <= s0_pcty_reg;
        end
        if (load[2])
        begin
            s2_rx_reg    <= s1_rx_reg;
            s2_ry_reg    <= s1_ry_reg;
            s2_pat3x_reg <= s2_pat3x_next;
            s2_pat3y_reg <= s2_pat3y_next;
            s2_pbt2x_reg <= s1_pbt2x_reg;
            s2_pbt2y_reg <= s1_pbt2y_reg;
            s2_pat2x_reg <= s1_pat2x_reg;
            s2_pat2y_reg <= s1_pat2y_reg;
            s2_pbtx_reg  <= s1_pbtx_reg;
            s2_pbty_reg  <= s1_pbty_reg;
            s2_pctx_reg  <= s1_pctx_reg;
            s2_pcty_reg  <= s1_pcty_reg;
        end
        if (load[3])
        begin
            s3_rx_reg <= s2_rx_reg;
            s3_ry_reg <= s2_ry_reg;
            s3_px_reg <= s3_px_next;
            s3_py_reg <= s3_py_next;
            s3_dx_reg <= s3_dx_next;
            s3_dy_reg <= s3_dy_next;
        end
        if (load[4])
        begin
            s4_ex_reg  <= s4_ex_next;
            s4_ey_reg  <= s4_ey_next;
            s4_mdx_reg <= s4_mdx_next;
            s4_mdy_reg <= s4_mdy_next;
            s4_sqx_reg <= (2*W)'(s4_mdx_next) * (2*W)'(s4_mdx_next);
            s4_sqy_reg <= (2*W)'(s4_mdy_next) * (2*W)'(s4_mdy_next);
            s4_sdx_reg <= s3_dx_reg[W-1];
            s4_sdy_reg <= s3_dy_reg[W-1];
        end
        if (load[5])
        begin
            s5_s_reg   <= s4_sqx_reg + s4_sqy_reg;
            s5_ex_reg  <= s4_ex_reg;
            s5_ey_reg  <= s4_ey_reg;
            s5_mdx_reg <= s4_mdx_reg;
            s5_mdy_reg <= s4_mdy_reg;
            s5_sdx_reg <= s4_sdx_reg;
            s5_sdy_reg <= s4_sdy_reg;
        end
    end

    assign vld   = vld_reg;
    assign s_o   = s5_s_reg;
    assign ex_o  = s5_ex_reg;
    assign ey_o  = s5_ey_reg;
    assign mdx_o = s5_mdx_reg;
    assign mdy_o = s5_mdy_reg;
    assign sdx_o = s5_sdx_reg;
    assign sdy_o = s5_sdy_reg;

endmodule

// ===== rtl/core/scl_sqrt_cell.sv =====
module scl_sqrt_cell #(
    parameter int W  = 32,
    parameter int SW = 130
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scl_pkg::scl_ctl_t ctl,
    output logic              vld,
    input  logic [2*W-1:0]    rad_i,
    input  logic [W+1:0]      rem_i,
    input  logic [W-1:0]      root_i,
    input  logic [SW-1:0]     side_i,
    output logic [2*W-1:0]    rad_o,
    output logic [W+1:0]      rem_o,
    output logic [W-1:0]      root_o,
    output logic [SW-1:0]     side_o
);

    logic             vld_reg;
    logic [2*W-1:0]   rad_reg;
    logic [W+1:0]     rem_reg;
    logic [W-1:0]     root_reg;
    logic [SW-1:0]    side_reg;
    logic [W+3:0]     cur;
    logic [W+3:0]     trial;
    logic             ge;
    logic [W+1:0]     rem_next;
    logic [W-1:0]     root_next;

    // one root bit per cell
    always_comb
    begin
        cur       = {rem_i, rad_i[2*W-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (W+2)'(cur - trial) : cur[W+1:0];
        root_next = {root_i[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            vld_reg <= ctl.valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rad_reg  <= {rad_i[2*W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_i;
        end
    end

    assign vld    = vld_reg;
    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign side_o = side_reg;

endmodule

// ===== rtl/core/scl_div_cell.sv =====
module scl_div_cell #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SH = 16,
    parameter int SW = 66
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scl_pkg::scl_ctl_t ctl,
    output logic              vld,
    input  logic [W-1:0]      len_i,
    input  logic [W+F-1:0]    remx_i,
    input  logic [W+F-1:0]    remy_i,
    input  logic [F:0]        qx_i,
    input  logic [F:0]        qy_i,
    input  logic [SW-1:0]     side_i,
    output logic [W-1:0]      len_o,
    output logic [W+F-1:0]    remx_o,
    output logic [W+F-1:0]    remy_o,
    output logic [F:0]        qx_o,
    output logic [F:0]        qy_o,
    output logic [SW-1:0]     side_o
);

    logic             vld_reg;
    logic [W-1:0]     len_reg;
    logic [W+F-1:0]   remx_reg, remy_reg;
    logic [F:0]       qx_reg, qy_reg;
    logic [SW-1:0]    side_reg;
    logic [W+F-1:0]   dvs;
    logic [W+F-1:0]   remx_next, remy_next;
    logic [F:0]       qx_next, qy_next;

    // quotient bit SH of both tangent lanes
    always_comb
    begin
        dvs       = (W+F)'(len_i) << SH;
        remx_next = remx_i;
        remy_next = remy_i;
        qx_next   = qx_i;
        qy_next   = qy_i;
        if (remx_i >= dvs)
        begin
            remx_next   = remx_i - dvs;
            qx_next[SH] = 1'b1;
        end
        if (remy_i >= dvs)
        begin
            remy_next   = remy_i - dvs;
            qy_next[SH] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            vld_reg <= ctl.valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            len_reg  <= len_i;
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            side_reg <= side_i;
        end
    end

    assign vld    = vld_reg;
    assign len_o  = len_reg;
    assign remx_o = remx_reg;
    assign remy_o = remy_reg;
    assign qx_o   = qx_reg;
    assign qy_o   = qy_reg;
    assign side_o = side_reg;

endmodule

// ===== rtl/core/scl_back.sv =====
module scl_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          load,
    input  logic                vin,
    output logic [1:0]          vld,
    input  logic [W-1:0]        len_i,
    input  logic [F:0]          qx_i,
    input  logic [F:0]          qy_i,
    input  logic                sdx_i,
    input  logic                sdy_i,
    input  logic signed [W-1:0] ex_i,
    input  logic signed [W-1:0] ey_i,
    output logic signed [W-1:0] contour_o,
    output logic signed [W-1:0] lag_o,
    output logic                degen_o
);

    localparam logic signed [W+2:0] SMAX = (W+3)'((64'd1 << (W-1)) - 64'd1);
    localparam logic signed [W+2:0] SMIN = -SMAX - (W+3)'(1);

    function automatic logic signed [W+2:0] ext(input logic signed [W-1:0] v);
        return (W+3)'(v);
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] v);
        logic signed [W+2:0] c;
        c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
        return c[W-1:0];
    endfunction

    logic [1:0]          vld_reg;
    logic [W-1:0]        magx, magy;
    logic signed [W-1:0] ux, uy;
    logic signed [W-1:0] b0_uyex_next, b0_uxey_next, b0_uxex_next, b0_uyey_next;
    logic signed [W-1:0] b0_uyex_reg, b0_uxey_reg, b0_uxex_reg, b0_uyey_reg;
    logic                b0_dg_reg;
    logic signed [W-1:0] b1_contour_reg, b1_lag_reg;
    logic                b1_dg_reg;
    logic signed [W-1:0] b1_contour_next, b1_lag_next;

    always_comb
    begin
        magx = {{(W-F-1){1'b0}}, qx_i};
        magy = {{(W-F-1){1'b0}}, qy_i};
        ux   = sdx_i ? W'(-$signed(magx)) : $signed(magx);
        uy   = sdy_i ? W'(-$signed(magy)) : $signed(magy);
    end

    scl_qmul #(.W(W), .F(F)) u_uyex (.a(uy), .b(ex_i), .p(b0_uyex_next));
    scl_qmul #(.W(W), .F(F)) u_uxey (.a(ux), .b(ey_i), .p(b0_uxey_next));
    scl_qmul #(.W(W), .F(F)) u_uxex (.a(ux), .b(ex_i), .p(b0_uxex_next));
    scl_qmul #(.W(W), .F(F)) u_uyey (.a(uy), .b(ey_i), .p(b0_uyey_next));

    always_comb
    begin
        b1_contour_next = b0_dg_reg ? '0 : sat(ext(b0_uyex_reg) - ext(b0_uxey_reg));
        b1_lag_next     = b0_dg_reg ? '0 : sat(-ext(b0_uxex_reg) - ext(b0_uyey_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[0]) vld_reg[0] <= vin;
            if (load[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            b0_uyex_reg <= b0_uyex_next;
            b0_uxey_reg <= b0_uxey_next;
            b0_uxex_reg <= b0_uxex_next;
            b0_uyey_reg <= b0_uyey_next;
            b0_dg_reg   <= (len_i == '0);
        end
        if (load[1])
        begin
            b1_contour_reg <= b1_contour_next;
            b1_lag_reg     <= b1_lag_next;
            b1_dg_reg      <= b0_dg_reg;
        end
    end

    assign vld       = vld_reg;
    assign contour_o = b1_contour_reg;
    assign lag_o     = b1_lag_reg;
    assign degen_o   = b1_dg_reg;

endmodule

// ===== rtl/core/spline_contour_lag_error.sv =====
// channel | dir | word
// cfg     | in  | index, data: coefficient write, always ready
// pos     | in  | robot_x, robot_y, path_offset
// err     | out | contour_err, lag_error, degenerate
//
// One word per cycle sustained while err is ready. The stages, in order, are the
// front polynomial stages, one root bit per cell, one quotient bit per cell and
// two back stages (products, then saturated sums). Every stage has its own valid flop.
// A stage loads when it is empty or the next stage loads, so gaps close up
// under an output stall. Reset clears valid flops and coefficients.
`include "spline_contour_lag_error_defines.svh"

module spline_contour_lag_error #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    scl_cfg_if.sink       cfg,
    scl_pos_if.sink       pos,
    scl_err_if.source     err
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int FS  = scl_pkg::FRONT_STAGES;
    localparam int DS  = FS + W;
    localparam int BS  = DS + F + 1;
    localparam int NST = BS + scl_pkg::BACK_STAGES;
    localparam int SQW = 4*W + 2;
    localparam int DVW = 2*W + 2;

    logic signed [W-1:0] coef_reg [scl_pkg::NUM_COEF];
    logic [NST-1:0]      vld;
    logic [NST:0]        adv;

    logic [2*W-1:0]      f_s;
    logic signed [W-1:0] f_ex, f_ey;
    logic [W-1:0]        f_mdx, f_mdy;
    logic                f_sdx, f_sdy;

    logic [2*W-1:0]      rad_w  [W+1];
    logic [W+1:0]        rem_w  [W+1];
    logic [W-1:0]        root_w [W+1];
    logic [SQW-1:0]      sqs_w  [W+1];

    logic [W-1:0]        len_w  [F+2];
    logic [W+F-1:0]      remx_w [F+2];
    logic [W+F-1:0]      remy_w [F+2];
    logic [F:0]          qx_w   [F+2];
    logic [F:0]          qy_w   [F+2];
    logic [DVW-1:0]      dvs_w  [F+2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scl_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg.valid && (cfg.index < scl_pkg::NUM_COEF_IDX))
        begin
            coef_reg[cfg.index[scl_pkg::COEF_SEL_W-1:0]] <= $signed(cfg.data);
        end
    end

    assign cfg.ready = 1'b1;

    assign adv[NST] = err.ready;
    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_adv
            assign adv[k] = !vld[k] || adv[k+1];
        end
    endgenerate

    assign pos.ready = adv[0];

    scl_front #(.W(W), .F(F)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (adv[FS-1:0]),
        .vin   (pos.valid),
        .vld   (vld[FS-1:0]),
        .coef  (coef_reg),
        .rx_i  (pos.robot_x),
        .ry_i  (pos.robot_y),
        .t_i   (pos.path_offset),
        .s_o   (f_s),
        .ex_o  (f_ex),
        .ey_o  (f_ey),
        .mdx_o (f_mdx),
        .mdy_o (f_mdy),
        .sdx_o (f_sdx),
        .sdy_o (f_sdy)
    );

    assign rad_w[0]  = f_s;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign sqs_w[0]  = {f_ex, f_ey, f_mdx, f_mdy, f_sdx, f_sdy};

    generate
        for (k = 0; k < W; k++)
        begin : g_sqrt
            scl_pkg::scl_ctl_t ctl;
            assign ctl.load     = adv[FS+k];
            assign ctl.valid_in = vld[FS+k-1];
            scl_sqrt_cell #(.W(W), .SW(SQW)) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .vld    (vld[FS+k]),
                .rad_i  (rad_w[k]),
                .rem_i  (rem_w[k]),
                .root_i (root_w[k]),
                .side_i (sqs_w[k]),
                .rad_o  (rad_w[k+1]),
                .rem_o  (rem_w[k+1]),
                .root_o (root_w[k+1]),
                .side_o (sqs_w[k+1])
            );
        end
    endgenerate

    assign len_w[0]  = root_w[W];
    assign remx_w[0] = {sqs_w[W][2*W+1 -: W], {F{1'b0}}};
    assign remy_w[0] = {sqs_w[W][W+1 -: W], {F{1'b0}}};
    assign qx_w[0]   = '0;
    assign qy_w[0]   = '0;
    assign dvs_w[0]  = {sqs_w[W][4*W+1 -: 2*W], sqs_w[W][1:0]};

    generate
        for (k = 0; k <= F; k++)
        begin : g_div
            scl_pkg::scl_ctl_t ctl;
            assign ctl.load     = adv[DS+k];
            assign ctl.valid_in = vld[DS+k-1];
            scl_div_cell #(.W(W), .F(F), .SH(F-k), .SW(DVW)) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .vld    (vld[DS+k]),
                .len_i  (len_w[k]),
                .remx_i (remx_w[k]),
                .remy_i (remy_w[k]),
                .qx_i   (qx_w[k]),
                .qy_i   (qy_w[k]),
                .side_i (dvs_w[k]),
                .len_o  (len_w[k+1]),
                .remx_o (remx_w[k+1]),
                .remy_o (remy_w[k+1]),
                .qx_o   (qx_w[k+1]),
                .qy_o   (qy_w[k+1]),
                .side_o (dvs_w[k+1])
            );
        end
    endgenerate

    scl_back #(.W(W), .F(F)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv[NST-1:BS]),
        .vin       (vld[BS-1]),
        .vld       (vld[NST-1:BS]),
        .len_i     (len_w[F+1]),
        .qx_i      (qx_w[F+1]),
        .qy_i      (qy_w[F+1]),
        .sdx_i     (dvs_w[F+1][1]),
        .sdy_i     (dvs_w[F+1][0]),
        .ex_i      ($signed(dvs_w[F+1][2*W+1 -: W])),
        .ey_i      ($signed(dvs_w[F+1][W+1 -: W])),
        .contour_o (err.contour_err),
        .lag_o     (err.lag_error),
        .degen_o   (err.degenerate)
    );

    assign err.valid = vld[NST-1];

    `SCL_ASSERT_IMP(a_degen_zero, clk, rst_n, err.valid && err.degenerate, err.contour_err == '0 && err.lag_error == '0)
    `SCL_ASSERT_IMP(a_front_empty_ready, clk, rst_n, !vld[0], pos.ready)
    `SCL_ASSERT_NXT(a_drain, clk, rst_n, err.ready && !vld[NST-2], !err.valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC = 16;
    localparam int DW = 32;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic signed [DW-1:0] robot_x;
        logic signed [DW-1:0] robot_y;
        logic signed [DW-1:0] path_offset;
    } position_t;

    typedef struct {
        logic signed [DW-1:0] contour_err;
        logic signed [DW-1:0] lag_error;
        logic                 degenerate;
    } tracking_err_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    scl_cfg_if #(DW) cfg_ch();
    scl_pos_if #(DW) pos_ch();
    scl_err_if #(DW) err_ch();

    spline_contour_lag_error #(.FRAC_BITS(FRAC), .DATA_WIDTH(DW)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .pos   (pos_ch.sink),
        .err   (err_ch.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic signed [DW-1:0] coef [scl_pkg::NUM_COEF];
    position_t            pending_positions [$];
    tracking_err_t        expected_errors [$];
    int                   fail_count = 0;
    int                   idle_cycles = 0;
    bit                   long_hold_req = 1'b0;

    function automatic longint clamp_word(longint v);
        if (v > MAXV)
            return MAXV;
        if (v < MINV)
            return MINV;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] wa, wb, p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> FRAC;
        if (p > MAXV)
            return MAXV;
        if (p < MINV)
            return MINV;
        return longint'(p);
    endfunction

    function automatic logic [127:0] mag(longint v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic tracking_err_t predict_errors(position_t p);
        tracking_err_t r;
        longint t, t2, t3, px, py, dx, dy, ex, ey, ux, uy;
        logic [127:0] sq, root, cand;
        t = p.path_offset;
        t2 = qmul(t, t);
        t3 = qmul(t2, t);
        px = clamp_word(qmul(coef[scl_pkg::COEF_X_CUBIC], t3)
                        + qmul(coef[scl_pkg::COEF_X_SQUARE], t2)
                        + qmul(coef[scl_pkg::COEF_X_LINEAR], t) + coef[scl_pkg::COEF_X_CONST]);
        py = clamp_word(qmul(coef[scl_pkg::COEF_Y_CUBIC], t3)
                        + qmul(coef[scl_pkg::COEF_Y_SQUARE], t2)
                        + qmul(coef[scl_pkg::COEF_Y_LINEAR], t) + coef[scl_pkg::COEF_Y_CONST]);
        dx = clamp_word(3 * qmul(coef[scl_pkg::COEF_X_CUBIC], t2)
                        + 2 * qmul(coef[scl_pkg::COEF_X_SQUARE], t)
                        + coef[scl_pkg::COEF_X_LINEAR]);
        dy = clamp_word(3 * qmul(coef[scl_pkg::COEF_Y_CUBIC], t2)
                        + 2 * qmul(coef[scl_pkg::COEF_Y_SQUARE], t)
                        + coef[scl_pkg::COEF_Y_LINEAR]);
        ex = clamp_word(longint'(p.robot_x) - px);
        ey = clamp_word(longint'(p.robot_y) - py);
        sq = mag(dx) * mag(dx) + mag(dy) * mag(dy);
        root = 0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            cand = root | (128'd1 << i);
            if (cand * cand <= sq)
                root = cand;
        end
        if (root == 0)
        begin
            r.contour_err = '0;
            r.lag_error = '0;
            r.degenerate = 1'b1;
            return r;
        end
        ux = longint'((mag(dx) << FRAC) / root);
        uy = longint'((mag(dy) << FRAC) / root);
        if (dx < 0)
            ux = -ux;
        if (dy < 0)
            uy = -uy;
        r.contour_err = clamp_word(qmul(uy, ex) - qmul(ux, ey));
        r.lag_error = clamp_word(-qmul(ux, ex) - qmul(uy, ey));
        r.degenerate = 1'b0;
        return r;
    endfunction

    // sender: bursts and gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && (!pos_ch.valid || pos_ch.ready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                pos_ch.valid <= 1'b0;
            end
            else if (pending_positions.size() > 0)
            begin
                position_t p;
                p = pending_positions.pop_front();
                pos_ch.robot_x <= p.robot_x;
                pos_ch.robot_y <= p.robot_y;
                pos_ch.path_offset <= p.path_offset;
                pos_ch.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pos_ch.valid <= 1'b0;
        end
    end

    // receiver: stall pattern with phases of no stall, plus one long hold-off
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req != hold_seen)
            begin
                hold_seen <= long_hold_req;
                hold_left <= LONG_HOLD;
                err_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                err_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(16, 120);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: err_ch.ready <= 1'b1;
                    1: err_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: err_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < scl_pkg::NUM_COEF_IDX)
                coef[cfg_ch.index[scl_pkg::COEF_SEL_W-1:0]] = cfg_ch.data;
            if (pos_ch.valid && pos_ch.ready)
            begin
                position_t p;
                p.robot_x = pos_ch.robot_x;
                p.robot_y = pos_ch.robot_y;
                p.path_offset = pos_ch.path_offset;
                expected_errors = {expected_errors, predict_errors(p)};
            end
            if (err_ch.valid && err_ch.ready)
            begin
                tracking_err_t e;
                if (expected_errors.size() == 0)
                begin
                    $display("%0t: unexpected word contour=%h lag=%h degenerate=%b", $time,
                             err_ch.contour_err, err_ch.lag_error, err_ch.degenerate);
                    fail_count++;
                end
                else
                begin
                    e = expected_errors.pop_front();
                    if (e.contour_err !== err_ch.contour_err)
                    begin
                        $display("%0t: contour_err expected %h actual %h", $time,
                                 e.contour_err, err_ch.contour_err);
                        fail_count++;
                    end
                    if (e.lag_error !== err_ch.lag_error)
                    begin
                        $display("%0t: lag_error expected %h actual %h", $time,
                                 e.lag_error, err_ch.lag_error);
                        fail_count++;
                    end
                    if (e.degenerate !== err_ch.degenerate)
                    begin
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 e.degenerate, err_ch.degenerate);
                        fail_count++;
                    end
                end
            end
            if ((pos_ch.valid && pos_ch.ready) || (err_ch.valid && err_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [DW-1:0] pick_value(int spread);
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3, 4, 5: return $urandom;
            default: return $signed($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    task automatic write_coef(input int idx, input logic [DW-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= (scl_pkg::CFG_IDX_W)'(idx);
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_position(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                  input logic [DW-1:0] t);
        position_t p;
        p.robot_x = x;
        p.robot_y = y;
        p.path_offset = t;
        pending_positions = {pending_positions, p};
    endtask

    // checked at the falling edge, once the rising-edge updates have settled
    task automatic drain;
        while (pending_positions.size() > 0 || expected_errors.size() > 0 || pos_ch.valid)
            @(negedge clk);
        repeat (70) @(posedge clk);
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        pos_ch.valid = 1'b0;
        pos_ch.robot_x = '0;
        pos_ch.robot_y = '0;
        pos_ch.path_offset = '0;
        err_ch.ready = 1'b0;
        for (int i = 0; i < scl_pkg::NUM_COEF; i++)
            coef[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // all coefficients zero after reset: zero tangent
        queue_position(32'h7fffffff, 32'h80000000, 32'h00010000);
        queue_position(32'h0, 32'h0, 32'h80000000);
        drain();

        // straight line with unit slope in x
        write_coef(scl_pkg::COEF_X_LINEAR, 32'h00010000);
        write_coef(scl_pkg::COEF_Y_LINEAR, 32'h00008000);
        write_coef(scl_pkg::COEF_X_CONST, 32'hfffe0000);
        write_coef(scl_pkg::COEF_Y_CONST, 32'h00030000);
        queue_position(32'h0, 32'h0, 32'h0);
        queue_position(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_position(32'h80000000, 32'h80000000, 32'h80000000);
        queue_position(32'h7fffffff, 32'h80000000, 32'hffffffff);
        queue_position(32'h00050000, 32'hfffb0000, 32'h00018000);
        drain();

        // full curve, then saturating extremes, plus ignored indexes
        write_coef(scl_pkg::COEF_X_CUBIC, 32'h00004000);
        write_coef(scl_pkg::COEF_X_SQUARE, 32'hffff0000);
        write_coef(scl_pkg::COEF_Y_CUBIC, 32'hffffc000);
        write_coef(scl_pkg::COEF_Y_SQUARE, 32'h00020000);
        queue_position(32'h00010000, 32'h00020000, 32'h00020000);
        queue_position(32'hfff00000, 32'h00100000, 32'hfffe0000);
        queue_position(32'h12345678, 32'hedcba987, 32'h00100000);
        drain();
        for (int i = 0; i < scl_pkg::NUM_COEF; i++)
            write_coef(i, 32'h7fffffff);
        write_coef(scl_pkg::NUM_COEF_IDX, 32'h0);
        write_coef(4'hf, 32'h0);
        queue_position(32'h80000000, 32'h80000000, 32'h7fffffff);
        queue_position(32'h7fffffff, 32'h0, 32'h80000000);
        queue_position(32'h0, 32'h0, 32'h0);
        drain();
        for (int i = 0; i < scl_pkg::NUM_COEF; i++)
            write_coef(i, 32'h80000000);
        queue_position(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_position(32'h80000000, 32'h7fffffff, 32'h80000000);
        queue_position(32'h1, 32'hffffffff, 32'h00010000);
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            int n_writes;
            n_writes = (ph == 0) ? scl_pkg::NUM_COEF : $urandom_range(1, scl_pkg::NUM_COEF + 2);
            for (int w = 0; w < n_writes; w++)
            begin
                int idx;
                idx = (ph == 0) ? w : $urandom_range(0, 9);
                write_coef(idx, pick_value(ph % 2 ? 32'h00040000 : 32'h01000000));
            end
            // tangent zero at offset zero once both linear coefficients are cleared
            if (ph == 4)
            begin
                write_coef(scl_pkg::COEF_X_LINEAR, 32'h0);
                write_coef(scl_pkg::COEF_Y_LINEAR, 32'h0);
                queue_position($urandom, $urandom, 32'h0);
            end
            for (int k = 0; k < 100; k++)
                queue_position(pick_value(32'h00400000), pick_value(32'h00400000),
                               pick_value(32'h00030000));
            if (ph == 2)
            begin
                while (pending_positions.size() > 60)
                    @(posedge clk);
                long_hold_req <= ~long_hold_req;
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
